@@ rtl/ncrs_pkg.sv @@
// Shared types and fixed-point helpers for the nonhyperbolic CRS traveltime block.
`timescale 1ns / 1ps
package ncrs_pkg;

  // Pipeline control that travels between the top level and its root units.
  typedef struct packed {
    logic en;     // advance every stage this cycle
    logic valid;  // item present at the unit's input
  } ncrs_ctl_t;

  localparam logic signed [63:0] QMAX = 64'sd2147483647;
  localparam logic signed [63:0] QMIN = -64'sd2147483648;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > QMAX) r = 32'sh7FFFFFFF;
    else if (v < QMIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round a Q.32 product to Q15.16 (add half, floor shift) and saturate.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return sat32(t);
  endfunction

endpackage

@@ rtl/nonhyperbolic_crs_traveltime.sv @@
// Top level of the nonhyperbolic CRS traveltime pipeline.
`timescale 1ns / 1ps
// Streams one grid point per cycle unless the output stalls: s_tdata carries a
// midpoint and a half-offset index, m_tdata returns the Q15.16 traveltime and
// m_tuser flags a negative radicand (time then forced to 0). Each item passes
// eight arithmetic stages (grid position, the three quadratic forms, the
// product of the side forms), a 33-stage inner square root, one summing stage,
// a 26-stage outer square root and the output register. A new point is taken
// every cycle; the whole pipeline holds while a result waits and is not taken.
// Registers are written through cfg_valid/cfg_index/cfg_data; the user must
// write them only while no point is in flight; the block does not enforce it.
// The write is always taken; indexes past the last register are dropped. The
// combined curvature term c1 = 2*b2 + a1^2 - a2 follows via the a1^2 and c1 registers.
module nonhyperbolic_crs_traveltime #(
  parameter int GRID_M = 1024,
  parameter int GRID_H = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // fields from bit 0: midpoint_index[9:0], half_offset_index[19:10], zero fill
  input  logic [23:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // fields from bit 0: travel_time[31:0]
  output logic [31:0] m_tdata,
  // fields from bit 0: negative_radicand
  output logic        m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [7:0] {
    REG_T0    = 8'd0,
    REG_MORG  = 8'd1,
    REG_HORG  = 8'd2,
    REG_MSTEP = 8'd3,
    REG_HSTEP = 8'd4,
    REG_A1    = 8'd5,
    REG_A2    = 8'd6,
    REG_B2    = 8'd7
  } cfg_reg_t;

  // Configuration registers.
  logic signed [31:0] t0, morg, horg, mstep, hstep, a1, a2, b2;
  logic signed [63:0] a1sq_p;
  logic signed [31:0] c1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0    <= '0;
      morg  <= '0;
      horg  <= '0;
      mstep <= 32'sd65536;
      hstep <= 32'sd65536;
      a1    <= '0;
      a2    <= '0;
      b2    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_T0:    t0    <= cfg_data;
        REG_MORG:  morg  <= cfg_data;
        REG_HORG:  horg  <= cfg_data;
        REG_MSTEP: mstep <= cfg_data;
        REG_HSTEP: hstep <= cfg_data;
        REG_A1:    a1    <= cfg_data;
        REG_A2:    a2    <= cfg_data;
        REG_B2:    b2    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derive c1 from the registers; items close behind a write may see a stale c1.
  always_ff @(posedge clk) begin
    a1sq_p <= a1 * a1;
    c1 <= ncrs_pkg::sat32(64'(ncrs_pkg::sat32(64'(ncrs_pkg::sat32(64'(b2) * 64'sd2))
          + 64'(ncrs_pkg::qround(a1sq_p)))) - 64'(a2));
  end

  // Global advance: hold everything while the output waits.
  logic en;
  assign en       = m_tready || !m_tvalid;
  assign s_tready = en;

  logic [8:1] v;

  // Clamp the indices to the grid.
  logic [9:0] im_c, ih_c;
  always_comb begin
    im_c = s_tdata[9:0];
    ih_c = s_tdata[19:10];
    if ({7'b0, s_tdata[9:0]} > 17'(GRID_M - 1)) im_c = 10'(GRID_M - 1);
    if ({7'b0, s_tdata[19:10]} > 17'(GRID_H - 1)) ih_c = 10'(GRID_H - 1);
  end

  logic signed [42:0] s1_pm, s1_ph;
  logic signed [31:0] s2_m, s2_h;
  logic signed [31:0] s3_x [3];
  logic signed [63:0] s3_hhp;
  logic signed [63:0] s4_pa1 [3];
  logic signed [63:0] s4_pa2 [3];
  logic signed [31:0] s4_x [3];
  logic signed [31:0] s4_hh;
  logic signed [31:0] s5_u [3];
  logic signed [31:0] s5_qa [3];
  logic signed [31:0] s5_x [3];
  logic signed [63:0] s5_chp;
  logic signed [63:0] s6_uup [3];
  logic signed [63:0] s6_qxp [3];
  logic signed [31:0] s6_ch;
  logic signed [31:0] s7_f [3];
  logic signed [31:0] s7_ch;
  logic signed [63:0] s8_prod;
  logic signed [33:0] s8_fmch;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], s_tvalid};
    end
    if (en) begin
      // grid offsets
      s1_pm <= $signed({1'b0, im_c}) * mstep;
      s1_ph <= $signed({1'b0, ih_c}) * hstep;
      // midpoint and half offset
      s2_m <= ncrs_pkg::sat32(64'(morg) + 64'(s1_pm));
      s2_h <= ncrs_pkg::sat32(64'(horg) + 64'(s1_ph));
      // the three arguments of the quadratic form
      s3_x[0] <= s2_m;
      s3_x[1] <= ncrs_pkg::sat32(64'(s2_m) - 64'(s2_h));
      s3_x[2] <= ncrs_pkg::sat32(64'(s2_m) + 64'(s2_h));
      s3_hhp  <= s2_h * s2_h;
      s4_hh   <= ncrs_pkg::qround(s3_hhp);
      s5_chp  <= c1 * s4_hh;
      s6_ch   <= ncrs_pkg::qround(s5_chp);
      s7_ch   <= s6_ch;
      for (int i = 0; i < 3; i++) begin
        s4_pa1[i] <= a1 * s3_x[i];
        s4_pa2[i] <= a2 * s3_x[i];
        s4_x[i]   <= s3_x[i];
        s5_u[i]   <= ncrs_pkg::sat32(64'(t0) + 64'(ncrs_pkg::qround(s4_pa1[i])));
        s5_qa[i]  <= ncrs_pkg::qround(s4_pa2[i]);
        s5_x[i]   <= s4_x[i];
        s6_uup[i] <= s5_u[i] * s5_u[i];
        s6_qxp[i] <= s5_qa[i] * s5_x[i];
        s7_f[i]   <= ncrs_pkg::sat32(64'(ncrs_pkg::qround(s6_uup[i]))
                     + 64'(ncrs_pkg::qround(s6_qxp[i])));
      end
      // product of the side forms, and F(m) + c1*h^2 kept exact
      s8_prod <= s7_f[1] * s7_f[2];
      s8_fmch <= 34'(s7_f[0]) + 34'(s7_ch);
    end
  end

  // Inner root of F(m-h)*F(m+h); a negative product feeds zero and sets the flag.
  ncrs_pkg::ncrs_ctl_t ctl1, ctl2;
  logic        r1_valid, r2_valid;
  logic [32:0] r1_root;
  logic [34:0] r1_side;
  logic [25:0] r2_root;
  logic        r2_neg;

  assign ctl1.en    = en;
  assign ctl1.valid = v[8];

  ncrs_sqrt #(.W(64), .SW(35)) u_inner (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (ctl1),
    .in_rad   (s8_prod[63] ? 64'd0 : s8_prod),
    .in_side  ({s8_prod[63], s8_fmch}),
    .out_valid(r1_valid),
    .out_root (r1_root),
    .out_side (r1_side)
  );

  // Saturate the inner root, form the outer radicand.
  logic [31:0]        inner;
  logic signed [34:0] s_sum;
  logic signed [34:0] s10_s;
  logic               s10_neg, s10_v;

  assign inner = (r1_root > 33'h07FFFFFFF) ? 32'h7FFFFFFF : r1_root[31:0];
  assign s_sum = 35'($signed(r1_side[33:0])) + $signed({3'b0, inner});

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= r1_valid;
    end
    if (en) begin
      s10_s   <= s_sum;
      s10_neg <= r1_side[34] || s_sum[34];
    end
  end

  assign ctl2.en    = en;
  assign ctl2.valid = s10_v;

  // Outer root of S*2^15.
  ncrs_sqrt #(.W(50), .SW(1)) u_outer (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (ctl2),
    .in_rad   (s10_neg ? 50'd0 : {1'b0, s10_s[33:0], 15'b0}),
    .in_side  (s10_neg),
    .out_valid(r2_valid),
    .out_root (r2_root),
    .out_side (r2_neg)
  );

  // Output register: hold until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r2_valid;
    end
    if (en) begin
      m_tdata <= r2_neg ? 32'd0 : {6'b0, r2_root};
      m_tuser <= r2_neg;
    end
  end

  // A flagged result always carries zero time.
  a_neg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("flagged result carries nonzero time");

  // Nothing leaves the pipeline right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // An empty output stage never blocks the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A stalled pipeline keeps its output transaction.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

@@ rtl/ncrs_sqrt.sv @@
// Pipelined digit-by-digit square root, rounded to nearest, one result bit per stage.
`timescale 1ns / 1ps
module ncrs_sqrt #(
  parameter int W  = 64,
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  ncrs_pkg::ncrs_ctl_t in_ctl,
  input  logic [W-1:0]       in_rad,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic [W/2:0]       out_root,
  output logic [SW-1:0]      out_side
);

  localparam int N = W / 2;

  logic [W-1:0]  x_q [N+1];
  logic [W-1:0]  r_q [N+1];
  logic [SW-1:0] sd_q [N+1];
  logic          v_q [N+1];

  assign x_q[0]  = in_rad;
  assign r_q[0]  = '0;
  assign sd_q[0] = in_side;
  assign v_q[0]  = in_ctl.valid;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BITK = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
    logic [W:0] trial;
    assign trial = {1'b0, r_q[k]} + {1'b0, BITK};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (in_ctl.en) begin
        v_q[k+1] <= v_q[k];
      end
      if (in_ctl.en) begin
        sd_q[k+1] <= sd_q[k];
        if ({1'b0, x_q[k]} >= trial) begin
          x_q[k+1] <= x_q[k] - trial[W-1:0];
          r_q[k+1] <= (r_q[k] >> 1) + BITK;
        end else begin
          x_q[k+1] <= x_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
      end
    end
  end

  // Round up when the remainder exceeds the floor root.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ctl.en) begin
      out_valid <= v_q[N];
    end
    if (in_ctl.en) begin
      out_side <= sd_q[N];
      out_root <= r_q[N][W/2:0] + {{(W/2){1'b0}}, (x_q[N] > r_q[N])};
    end
  end

endmodule
